@@ design/dfia_pkg.sv @@
// dfia_pkg: shared types and constants for the deferred-free index allocator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package dfia_pkg;

  // Store geometry
  localparam int MAX_ENTRIES = 256;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = IDX_W + 1;
  localparam int FENCE_W     = 64;
  localparam int OP_W        = 3;
  localparam int CAP_W       = 9;

  // Capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_ACQUIRE = 3'd0,
    OP_RETIRE  = 3'd1,
    OP_RELEASE = 3'd2,
    OP_ADVANCE = 3'd3,
    OP_QUERY   = 3'd4
  } op_t;

  // Per-slot status
  typedef enum logic [1:0] {
    ST_UNAVAIL = 2'd0,
    ST_FREE    = 2'd1,
    ST_LIVE    = 2'd2,
    ST_RETIRED = 2'd3
  } slot_st_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_DONE = 2'd2
  } seq_state_t;

  // Store write command from the sequencer
  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   addr;
    slot_st_t           status;
    logic               fence_en;
    logic [FENCE_W-1:0] fence;
  } wr_cmd_t;

  // One result item
  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] granted;
  } result_t;

endpackage

@@ design/dfia_store.sv @@
// dfia_store: slot status and fence memories, per-slot valid bits, capacity register.
// Depends on dfia_pkg.
`timescale 1ns / 1ps

module dfia_store (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [dfia_pkg::CAP_W-1:0]      cfg_cap,
  input  logic [dfia_pkg::IDX_W-1:0]      rd_addr,
  input  dfia_pkg::wr_cmd_t               wr,
  output dfia_pkg::slot_st_t              rd_status,
  output logic [dfia_pkg::FENCE_W-1:0]    rd_fence
);
  import dfia_pkg::*;

  slot_st_t               status_mem [MAX_ENTRIES];
  logic [FENCE_W-1:0]     fence_mem  [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] vld_r;
  logic [CAP_W-1:0]       cap_r;
  slot_st_t               rd_raw_r;
  logic                   rd_vld_r;
  logic [IDX_W-1:0]       rd_addr_r;
  logic [CNT_W-1:0]       eff_cap;

  // Capacity register; a write wipes all slot contents via the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
      vld_r <= '0;
    end else if (cfg_we) begin
      cap_r <= cfg_cap;
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  // Memory write ports
  always_ff @(posedge clk) begin
    if (wr.en) begin
      status_mem[wr.addr] <= wr.status;
    end
    if (wr.fence_en) begin
      fence_mem[wr.addr] <= wr.fence;
    end
  end

  // Registered reads
  always_ff @(posedge clk) begin
    rd_raw_r  <= status_mem[rd_addr];
    rd_fence  <= fence_mem[rd_addr];
    rd_vld_r  <= vld_r[rd_addr];
    rd_addr_r <= rd_addr;
  end

  // Capacity clamped to the store size
  assign eff_cap = (cap_r > CAP_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : CNT_W'(cap_r);

  // Untouched slot: free inside 1..cap-1, otherwise unavailable
  always_comb begin
    if (rd_vld_r) begin
      rd_status = rd_raw_r;
    end else if (rd_addr_r != '0 && {1'b0, rd_addr_r} < eff_cap) begin
      rd_status = ST_FREE;
    end else begin
      rd_status = ST_UNAVAIL;
    end
  end

endmodule

@@ design/dfia_seq.sv @@
// dfia_seq: scan sequencer with the shared fence comparator; walks the store one slot a cycle.
// Depends on dfia_pkg.
`timescale 1ns / 1ps

module dfia_seq (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [dfia_pkg::OP_W-1:0]       in_op,
  input  logic [dfia_pkg::IDX_W-1:0]      in_idx,
  input  logic [dfia_pkg::FENCE_W-1:0]    in_fence,
  output logic [dfia_pkg::IDX_W-1:0]      rd_addr,
  input  dfia_pkg::slot_st_t              rd_status,
  input  logic [dfia_pkg::FENCE_W-1:0]    rd_fence,
  output dfia_pkg::wr_cmd_t               wr,
  input  logic                            out_space,
  output logic                            res_load,
  output dfia_pkg::result_t               res
);
  import dfia_pkg::*;

  seq_state_t         state_r, state_nxt;
  logic [OP_W-1:0]    op_r, op_nxt;
  logic [FENCE_W-1:0] fence_r, fence_nxt;
  logic [CNT_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic [CNT_W-1:0]   scan_end_r, scan_end_nxt;
  logic               eval_vld_r, eval_vld_nxt;
  logic [IDX_W-1:0]   eval_idx_r, eval_idx_nxt;
  logic               res_ok_r, res_ok_nxt;
  logic [IDX_W-1:0]   res_grant_r, res_grant_nxt;
  logic               in_fire;
  logic               issue;
  logic               fence_le;
  logic               acq_hit;

  // No transfer is taken while reset is held
  assign in_ready = (state_r == S_IDLE) && rst_n;
  assign in_fire  = in_valid && in_ready;
  assign issue    = (scan_idx_r < scan_end_r);
  assign rd_addr  = scan_idx_r[IDX_W-1:0];

  // Shared comparator: stored fence at or below the completed value
  assign fence_le = (rd_fence <= fence_r);

  assign acq_hit  = eval_vld_r && (op_r == OP_ACQUIRE) && (rd_status == ST_FREE);

  assign res_load = (state_r == S_DONE) && out_space;
  assign res.ok      = res_ok_r;
  assign res.granted = res_grant_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_op inside {OP_ACQUIRE, OP_RETIRE, OP_RELEASE, OP_ADVANCE, OP_QUERY}) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (acq_hit || !issue) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_space) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and store commands
  always_comb begin
    op_nxt        = op_r;
    fence_nxt     = fence_r;
    scan_idx_nxt  = scan_idx_r;
    scan_end_nxt  = scan_end_r;
    eval_vld_nxt  = 1'b0;
    eval_idx_nxt  = eval_idx_r;
    res_ok_nxt    = res_ok_r;
    res_grant_nxt = res_grant_r;
    wr            = '0;
    wr.addr       = eval_idx_r;
    wr.fence      = fence_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt        = in_op;
          fence_nxt     = in_fence;
          res_ok_nxt    = 1'b0;
          res_grant_nxt = '0;
          case (in_op)
            OP_ACQUIRE: begin
              scan_idx_nxt = CNT_W'(1);
              scan_end_nxt = CNT_W'(MAX_ENTRIES);
            end
            OP_ADVANCE: begin
              scan_idx_nxt = '0;
              scan_end_nxt = CNT_W'(MAX_ENTRIES);
              res_ok_nxt   = 1'b1;
            end
            default: begin
              // single-slot operations visit just the named index
              scan_idx_nxt = {1'b0, in_idx};
              scan_end_nxt = {1'b0, in_idx} + CNT_W'(1);
            end
          endcase
        end
      end
      S_SCAN: begin
        // issue the next read while evaluating the previous one
        if (issue) begin
          scan_idx_nxt = scan_idx_r + CNT_W'(1);
          eval_vld_nxt = 1'b1;
          eval_idx_nxt = scan_idx_r[IDX_W-1:0];
        end
        if (eval_vld_r) begin
          case (op_r)
            OP_ACQUIRE: begin
              if (rd_status == ST_FREE) begin
                wr.en         = 1'b1;
                wr.status     = ST_LIVE;
                res_ok_nxt    = 1'b1;
                res_grant_nxt = eval_idx_r;
                eval_vld_nxt  = 1'b0;
              end
            end
            OP_RETIRE: begin
              if (eval_idx_r != '0 && rd_status == ST_LIVE) begin
                wr.en       = 1'b1;
                wr.status   = ST_RETIRED;
                wr.fence_en = 1'b1;
                res_ok_nxt  = 1'b1;
              end
            end
            OP_RELEASE: begin
              if (eval_idx_r != '0 && rd_status == ST_LIVE) begin
                wr.en      = 1'b1;
                wr.status  = ST_FREE;
                res_ok_nxt = 1'b1;
              end
            end
            OP_ADVANCE: begin
              if (rd_status == ST_RETIRED && fence_le) begin
                wr.en     = 1'b1;
                wr.status = ST_FREE;
              end
            end
            OP_QUERY: begin
              res_ok_nxt = (rd_status == ST_RETIRED);
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      eval_vld_r <= 1'b0;
      scan_idx_r <= '0;
      scan_end_r <= '0;
    end else begin
      state_r    <= state_nxt;
      eval_vld_r <= eval_vld_nxt;
      scan_idx_r <= scan_idx_nxt;
      scan_end_r <= scan_end_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    fence_r     <= fence_nxt;
    eval_idx_r  <= eval_idx_nxt;
    res_ok_r    <= res_ok_nxt;
    res_grant_r <= res_grant_nxt;
  end

`ifndef SYNTHESIS
  // Reserved index zero is never written, except possibly by an advance scan
  a_no_wr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (wr.addr != '0 || op_r == OP_ADVANCE))
    else $error("status write to reserved index");

  // Store writes only happen while a read result is being evaluated
  a_wr_in_eval: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (state_r == S_SCAN && eval_vld_r))
    else $error("store write outside evaluation");

  // A granted index always comes with success
  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    res_load && res.granted != '0 |-> res.ok && op_r == OP_ACQUIRE)
    else $error("grant without success");

  // An accepted item leaves the idle state
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != S_IDLE)
    else $error("sequencer idle after accept");
`endif

endmodule

@@ design/deferred_free_index_allocator.sv @@
// deferred_free_index_allocator: top level; stream ports, output register, sequencer and store.
// Depends on dfia_pkg, dfia_store, dfia_seq.
//
//   channel  dir  handshake                 payload
//   in       in   in_tvalid / in_tready     in_tdata (index, fence), in_tuser (operation)
//   out      out  out_tvalid / out_tready   out_tdata (ok, granted index)
//   cfg      in   cfg_valid / cfg_ready     cfg_data (capacity)
//
// Retire, release and query read only the named slot; unused codes skip the scan state.
// Acquire scans from index 1 and stops at the first free slot; advance visits every
// slot. Both walk the slot memory one entry per cycle through
// its single registered read port. Reset (rst_n, synchronous) or a capacity write
// reinitializes every slot at once. The result sits in an output register, so the
// next item is accepted while it waits; the sequencer stalls in its final state
// only while that register is still full.
`timescale 1ns / 1ps

module deferred_free_index_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // [7:0] slot_index, [71:8] fence_value
  input  logic [2:0]  in_tuser,   // [2:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] ok, [8:1] granted_index, [15:9] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data    // [8:0] capacity
);
  import dfia_pkg::*;

  logic               out_valid_r;
  result_t            out_res_r;
  logic               out_space;
  logic               res_load;
  result_t            res;
  logic               seq_ready;
  logic [IDX_W-1:0]   rd_addr;
  slot_st_t           rd_status;
  logic [FENCE_W-1:0] rd_fence;
  wr_cmd_t            wr;

  assign in_tready = seq_ready;
  assign cfg_ready = seq_ready;
  assign out_space = !out_valid_r || out_tready;

  dfia_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (seq_ready),
    .in_op     (in_tuser[OP_W-1:0]),
    .in_idx    (in_tdata[IDX_W-1:0]),
    .in_fence  (in_tdata[IDX_W +: FENCE_W]),
    .rd_addr   (rd_addr),
    .rd_status (rd_status),
    .rd_fence  (rd_fence),
    .wr        (wr),
    .out_space (out_space),
    .res_load  (res_load),
    .res       (res)
  );

  dfia_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_cap   (cfg_data),
    .rd_addr   (rd_addr),
    .wr        (wr),
    .rd_status (rd_status),
    .rd_fence  (rd_fence)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_res_r.granted, out_res_r.ok};

endmodule

@@ tb/tb_deferred_free_index_allocator.sv @@
// tb_deferred_free_index_allocator: self-checking testbench for the deferred-free index allocator.
// Holds a slot-store predictor, a directed table and randomized phases over several capacities.
// Depends on dfia_pkg and deferred_free_index_allocator.
`timescale 1ns / 1ps

module tb_deferred_free_index_allocator;
  import dfia_pkg::*;

  // Unused operation codes
  localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;
  localparam logic [FENCE_W-1:0] FENCE_MAX = '1;
  localparam int N_DIRECTED = 25;
  localparam int N_PHASES   = 9;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;   // [7:0] slot_index, [71:8] fence_value
  logic [2:0]  in_tuser = '0;   // [2:0] operation
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [15:0] out_tdata;       // [0] ok, [8:1] granted_index, [15:9] zero
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [8:0]  cfg_data = '0;   // [8:0] capacity

  deferred_free_index_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // One directed stimulus row; pinned rows carry the expected result inline
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [7:0]         idx;
    logic [FENCE_W-1:0] fence;
    bit                 pinned;
    bit                 ok;
    logic [7:0]         granted;
  } stim_row_t;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{OP_ACQUIRE, 8'd0,   64'd0,         1'b1, 1'b1, 8'd1},
    '{OP_ACQUIRE, 8'd0,   64'd0,         1'b1, 1'b1, 8'd2},
    '{OP_RETIRE,  8'd1,   64'd0,         1'b1, 1'b1, 8'd0},
    '{OP_QUERY,   8'd1,   64'd0,         1'b1, 1'b1, 8'd0},
    '{OP_QUERY,   8'd0,   64'd0,         1'b1, 1'b0, 8'd0},  // reserved index
    '{OP_RETIRE,  8'd0,   64'd5,         1'b1, 1'b0, 8'd0},
    '{OP_RELEASE, 8'd0,   64'd0,         1'b1, 1'b0, 8'd0},
    '{OP_RELEASE, 8'd2,   64'd0,         1'b1, 1'b1, 8'd0},
    '{OP_RELEASE, 8'd2,   64'd0,         1'b1, 1'b0, 8'd0},  // no longer live
    '{OP_ADVANCE, 8'd0,   64'd0,         1'b1, 1'b1, 8'd0},
    '{OP_QUERY,   8'd1,   64'd0,         1'b1, 1'b0, 8'd0},
    '{OP_ACQUIRE, 8'd0,   64'd0,         1'b0, 1'b0, 8'd0},
    '{OP_RETIRE,  8'd1,   FENCE_MAX,     1'b1, 1'b1, 8'd0},
    '{OP_ADVANCE, 8'd0,   FENCE_MAX - 1, 1'b1, 1'b1, 8'd0},  // fence one short
    '{OP_QUERY,   8'd1,   64'd0,         1'b1, 1'b1, 8'd0},
    '{OP_RELEASE, 8'd1,   64'd0,         1'b1, 1'b0, 8'd0},  // retired, not live
    '{OP_ADVANCE, 8'd255, FENCE_MAX,     1'b1, 1'b1, 8'd0},
    '{OP_QUERY,   8'd1,   64'd0,         1'b1, 1'b0, 8'd0},
    '{OP_RSVD_5,  8'd1,   FENCE_MAX,     1'b1, 1'b0, 8'd0},
    '{OP_RSVD_6,  8'd255, 64'd0,         1'b1, 1'b0, 8'd0},
    '{OP_RSVD_7,  8'd0,   64'd0,         1'b1, 1'b0, 8'd0},
    '{OP_QUERY,   8'd255, 64'd0,         1'b1, 1'b0, 8'd0},
    '{OP_RETIRE,  8'd255, 64'd0,         1'b1, 1'b0, 8'd0},  // free, not live
    '{OP_ACQUIRE, 8'd0,   64'd0,         1'b0, 1'b0, 8'd0},
    '{OP_RETIRE,  8'hAA,  64'h5555_AAAA_5555_AAAA, 1'b0, 1'b0, 8'd0}
  };

  // Randomized phases: capacity, item count, acquire weight in percent
  int ph_cap   [N_PHASES] = '{256, 0, 1, 2, 5, 511, 17, 129, 300};
  int ph_items [N_PHASES] = '{90, 15, 15, 40, 80, 300, 120, 100, 140};
  int ph_acq   [N_PHASES] = '{30, 40, 40, 40, 35, 85, 35, 30, 30};

  // Predictor state
  slot_st_t           slot_state [MAX_ENTRIES];
  logic [FENCE_W-1:0] slot_fence [MAX_ENTRIES];
  result_t            pending_results [$];
  logic [FENCE_W-1:0] fence_now;

  int  n_errors = 0;
  int  n_items = 0;
  int  n_cfg = 0;
  int  n_grants = 0;
  int  n_grant_fails = 0;
  int  n_fence_frees = 0;
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b0;
  int  rx_stall = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
    n_errors++;
  endtask

  function automatic void reinit_slots(input logic [8:0] cap);
    int eff;
    eff = (cap > MAX_ENTRIES) ? MAX_ENTRIES : int'(cap);
    if (eff > 256) eff = 256;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      slot_state[i] = (i >= 1 && i < eff) ? ST_FREE : ST_UNAVAIL;
      slot_fence[i] = '0;
    end
  endfunction

  // Apply one operation to the slot store and return its result
  function automatic result_t alloc_step(input logic [OP_W-1:0] op, input logic [7:0] idx,
                                         input logic [FENCE_W-1:0] fence);
    result_t r;
    bit      found;
    r = '0;
    found = 1'b0;
    case (op)
      OP_ACQUIRE: begin
        for (int i = 1; i < MAX_ENTRIES && i < 256; i++) begin
          if (!found && slot_state[i] == ST_FREE) begin
            slot_state[i] = ST_LIVE;
            r.ok = 1'b1;
            r.granted = IDX_W'(i);
            found = 1'b1;
          end
        end
        if (found) n_grants++;
        else n_grant_fails++;
      end
      OP_RETIRE: begin
        if (idx != 0 && slot_state[idx] == ST_LIVE) begin
          slot_state[idx] = ST_RETIRED;
          slot_fence[idx] = fence;
          r.ok = 1'b1;
        end
      end
      OP_RELEASE: begin
        if (idx != 0 && slot_state[idx] == ST_LIVE) begin
          slot_state[idx] = ST_FREE;
          r.ok = 1'b1;
        end
      end
      OP_ADVANCE: begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (slot_state[i] == ST_RETIRED && slot_fence[i] <= fence) begin
            slot_state[i] = ST_FREE;
            n_fence_frees++;
          end
        end
        r.ok = 1'b1;
      end
      OP_QUERY: r.ok = (slot_state[idx] == ST_RETIRED);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Random slot in the wanted state, or any index when none is
  function automatic logic [7:0] pick_slot(input slot_st_t want);
    int start;
    start = $urandom_range(0, 255);
    for (int k = 0; k < 256; k++) begin
      if (slot_state[(start + k) % 256] == want) return 8'((start + k) % 256);
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Present one item and hold it until the transfer; valid stays high afterwards
  task automatic send_item(input logic [OP_W-1:0] op, input logic [7:0] idx,
                           input logic [FENCE_W-1:0] fence, input bit pinned,
                           input result_t pinned_res);
    result_t r;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {fence, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = alloc_step(op, idx, fence);
    if (pinned) r = pinned_res;
    pending_results.insert(pending_results.size(), r);
    n_items++;
  endtask

  task automatic sender_gap();
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // Valid is already low when nothing is outstanding
  task automatic drain_results();
    if (pending_results.size() != 0) begin
      in_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
    end
  endtask

  task automatic write_capacity(input logic [8:0] cap);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    reinit_slots(cap);
    n_cfg++;
  endtask

  function automatic logic [FENCE_W-1:0] wild_fence();
    return {$urandom(), $urandom()};
  endfunction

  // Mostly well-formed lifecycles on real slots, with some noise mixed in
  task automatic send_random(input int acq_w);
    logic [OP_W-1:0]    op;
    logic [7:0]         idx;
    logic [FENCE_W-1:0] fence;
    int                 sel;
    idx = 8'($urandom_range(0, 255));
    fence = wild_fence();
    sel = $urandom_range(0, 99);
    if (sel < acq_w) begin
      op = OP_ACQUIRE;
    end else begin
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
        op = OP_RETIRE;
        if ($urandom_range(0, 4) != 0) idx = pick_slot(ST_LIVE);
        if ($urandom_range(0, 19) != 0) fence = fence_now + $urandom_range(0, 40);
      end else if (sel < 50) begin
        op = OP_RELEASE;
        if ($urandom_range(0, 4) != 0) idx = pick_slot(ST_LIVE);
      end else if (sel < 68) begin
        op = OP_ADVANCE;
        if ($urandom_range(0, 19) != 0) fence = fence_now;
        fence_now = fence_now + $urandom_range(0, 15);
      end else if (sel < 92) begin
        op = OP_QUERY;
        if ($urandom_range(0, 4) < 3) idx = pick_slot(ST_RETIRED);
      end else begin
        op = OP_RSVD_5 + 3'($urandom_range(0, 2));
      end
    end
    send_item(op, idx, fence, 1'b0, '0);
  endtask

  // Result receiver: random stall bursts on out_tready while rx_idle_on is set
  always @(posedge clk) begin
    if (!rst_n || !rx_idle_on) begin
      out_tready <= 1'b1;
      rx_stall   <= 0;
    end else if (rx_stall > 0) begin
      out_tready <= 1'b0;
      rx_stall   <= rx_stall - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      rx_stall   <= $urandom_range(0, 8);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with none expected", int'(out_tdata[8:0]), -1);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[0] !== want.ok)
          report_mismatch("ok", int'(out_tdata[0]), int'(want.ok));
        if (out_tdata[8:1] !== want.granted)
          report_mismatch("granted_index", int'(out_tdata[8:1]), int'(want.granted));
      end
    end
  end

  // Stimulus
  initial begin
    result_t pinned_res;
    int      n_ph;
    bit      last_ph;
    reinit_slots(CAP_RESET);
    fence_now = {$urandom(), $urandom()} >> 1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table under the reset capacity
    foreach (directed_rows[i]) begin
      pinned_res.ok = directed_rows[i].ok;
      pinned_res.granted = directed_rows[i].granted;
      send_item(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].fence,
                directed_rows[i].pinned, pinned_res);
      sender_gap();
    end

    // Random phases, each after a capacity write on an idle block
    for (int p = 0; p < N_PHASES; p++) begin
      last_ph = (p == N_PHASES - 1);
      write_capacity(9'(ph_cap[p]));
      n_ph = ph_items[p];
      for (int k = 0; k < n_ph; k++) begin
        if (k % 32 == 0) begin
          tx_idle_on = !last_ph && $urandom_range(0, 3) != 0;
          rx_idle_on <= !last_ph && $urandom_range(0, 3) != 0;
        end
        // hold off mid-phase until the block has caught up
        if (k == n_ph / 2) drain_results();
        send_random(ph_acq[p]);
        sender_gap();
      end
    end

    drain_results();
    repeat (300) @(posedge clk);
    $display("Ran %0d items over %0d capacity writes (0, 1, saturating 300 and 511 included).",
             n_items, n_cfg);
    $display("Acquires granted %0d, failed %0d; slots freed by fence advance %0d.",
             n_grants, n_grant_fails, n_fence_frees);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("Timed out with %0d results outstanding", pending_results.size());
    $display("FAILURE");
    $finish;
  end

endmodule
